// ===== hdl/rgbgm_pkg.sv =====
// Shared types and constants for the RGB gamut mapper.
package rgbgm_pkg;

  localparam int unsigned IN_W   = 20;
  localparam int unsigned OUT_W  = 17;
  localparam int unsigned W_BITS = 16;

  localparam int unsigned BISECT_STEPS_DEF = 20;
  localparam int unsigned FRAC_BITS_DEF    = 16;

  // Rec.709 luminance weights, Q0.16, summing to exactly 1.0
  localparam logic [W_BITS-1:0] W_RED   = 16'd13933;
  localparam logic [W_BITS-1:0] W_GREEN = 16'd46871;
  localparam logic [W_BITS-1:0] W_BLUE  = 16'd4732;

  typedef struct packed {
    logic valid;
    logic skip;
  } ctl_t;

endpackage

// ===== hdl/rgbgm_if.sv =====
// Handshake interfaces for the pixel, result and configuration channels.
interface rgbgm_in_if;
  import rgbgm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] red_in;
  logic signed [IN_W-1:0] green_in;
  logic signed [IN_W-1:0] blue_in;
  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rgbgm_out_if;
  import rgbgm_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red_out;
  logic [OUT_W-1:0] green_out;
  logic [OUT_W-1:0] blue_out;
  modport source (output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

interface rgbgm_cfg_if;
  logic valid;
  logic ready;
  logic map_method;
  modport source (output valid, output map_method, input ready);
  modport sink   (input valid, input map_method, output ready);
endinterface

// ===== hdl/rgbgm_step.sv =====
// One bisection round: multiply stage, then test-and-select stage.
module rgbgm_step #(
  parameter int unsigned BISECT_STEPS = rgbgm_pkg::BISECT_STEPS_DEF,
  parameter int unsigned FRAC_BITS    = rgbgm_pkg::FRAC_BITS_DEF,
  parameter int unsigned VAL_W        = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  rgbgm_pkg::ctl_t        ctl_i,
  input  logic [BISECT_STEPS:0]  lo_i,
  input  logic [BISECT_STEPS:0]  hi_i,
  input  logic [VAL_W-1:0]       gray_i,
  input  logic [2:0][VAL_W-1:0]  d_i,
  input  logic [2:0][VAL_W-1:0]  r_i,
  output rgbgm_pkg::ctl_t        ctl_o,
  output logic [BISECT_STEPS:0]  lo_o,
  output logic [BISECT_STEPS:0]  hi_o,
  output logic [VAL_W-1:0]       gray_o,
  output logic [2:0][VAL_W-1:0]  d_o,
  output logic [2:0][VAL_W-1:0]  r_o
);
  import rgbgm_pkg::*;

  localparam int unsigned TW = BISECT_STEPS + 1;
  localparam int unsigned PW = VAL_W + TW + 1;
  localparam logic signed [PW-1:0] RND =
    {{(PW-1){1'b0}}, 1'b1} << (BISECT_STEPS - 1);
  localparam logic signed [VAL_W-1:0] ONE =
    {{(VAL_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic [TW-1:0]         t;
  logic [2:0][PW-1:0]    prod_d;

  ctl_t                  p_ctl_q;
  logic [TW-1:0]         p_t_q, p_lo_q, p_hi_q;
  logic [VAL_W-1:0]      p_gray_q;
  logic [2:0][VAL_W-1:0] p_d_q, p_r_q;
  logic [2:0][PW-1:0]    p_prod_q;

  logic signed [PW-1:0]    rnd_sum [3];
  logic signed [PW-1:0]    shifted [3];
  logic signed [VAL_W-1:0] tp [3];
  logic [2:0]              in_rng;

  logic [TW-1:0]         lo_d, hi_d;
  logic [2:0][VAL_W-1:0] r_d;

  // midpoint is exact: hi - lo is a power of two
  assign t = (lo_i + hi_i) >> 1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = $signed(d_i[i]) * $signed({1'b0, t});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_ctl_q <= '0;
    end else if (en_i) begin
      p_ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_t_q    <= t;
      p_lo_q   <= lo_i;
      p_hi_q   <= hi_i;
      p_gray_q <= gray_i;
      p_d_q    <= d_i;
      p_r_q    <= r_i;
      p_prod_q <= prod_d;
    end
  end

  // round to nearest, ties up, then test the point against the unit cube
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_sum[i] = $signed(p_prod_q[i]) + RND;
      shifted[i] = rnd_sum[i] >>> BISECT_STEPS;
      tp[i]      = $signed(p_gray_q) + $signed(shifted[i][VAL_W-1:0]);
      in_rng[i]  = (tp[i] >= 0) && (tp[i] <= ONE);
    end
  end

  always_comb begin
    lo_d = p_lo_q;
    hi_d = p_hi_q;
    r_d  = p_r_q;
    if (!p_ctl_q.skip) begin
      if (&in_rng) begin
        lo_d = p_t_q;
        for (int i = 0; i < 3; i++) begin
          r_d[i] = tp[i];
        end
      end else begin
        hi_d = p_t_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= p_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_o   <= lo_d;
      hi_o   <= hi_d;
      gray_o <= p_gray_q;
      d_o    <= p_d_q;
      r_o    <= r_d;
    end
  end

endmodule

// ===== hdl/rgb_gamut_mapper_top.sv =====
// Top level of the RGB gamut mapper: luminance, bisection pipeline, output skid.
//
// Maps one linear RGB pixel (signed, FRAC_BITS fraction bits) into [0,1]^3 per
// word. map_method 0 clamps each channel; map_method 1 passes in-gamut pixels
// through and otherwise blends toward the clamped Rec.709 gray, bisecting over
// BISECT_STEPS rounds for the largest in-gamut blend factor. The block takes
// one pixel per clock while input ready is high. An accepted input word passes
// one input register, three luminance stages (weight multiply, sum and clamp,
// difference and mode select), two stages per bisection round (blend multiply,
// then round, test and select), and the output register on its way to the
// output. The pipeline moves as one; a one-word skid register behind it
// absorbs the word in flight when the output stalls, and input ready drops
// only while that skid register is full. map_method is sampled with each
// pixel as it enters, and the configuration channel is always ready.
module rgb_gamut_mapper_top #(
  parameter int unsigned BISECT_STEPS = rgbgm_pkg::BISECT_STEPS_DEF,
  parameter int unsigned FRAC_BITS    = rgbgm_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgbgm_cfg_if.sink   cfg_i,
  rgbgm_in_if.sink    in_i,
  rgbgm_out_if.source out_o
);
  import rgbgm_pkg::*;

  localparam int unsigned TW    = BISECT_STEPS + 1;
  localparam int unsigned VAL_W = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 4;
  localparam int unsigned MW    = IN_W + W_BITS + 1;
  localparam int unsigned ACC_W = MW + 2;
  localparam int unsigned LW    = ACC_W - W_BITS;
  localparam logic signed [ACC_W-1:0] LUM_RND =
    {{(ACC_W-1){1'b0}}, 1'b1} << (W_BITS - 1);
  localparam logic signed [VAL_W-1:0] ONE =
    {{(VAL_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [TW-1:0] T_FULL = {1'b1, {BISECT_STEPS{1'b0}}};

  function automatic logic signed [VAL_W-1:0] clamp_unit(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] res;
    res = v;
    if (v < 0) begin
      res = '0;
    end else if (v > ONE) begin
      res = ONE;
    end
    return res;
  endfunction

  // configuration
  logic map_method_q;

  // pipeline control
  logic pipe_en;
  logic skid_valid_q, skid_valid_d;
  logic out_valid_q, out_valid_d;

  // input register
  logic                 s1_valid_q;
  logic                 s1_method_q;
  logic [2:0][IN_W-1:0] s1_c_q;

  // weight products
  logic                 s2_valid_q;
  logic                 s2_method_q;
  logic [2:0][IN_W-1:0] s2_c_q;
  logic [2:0][MW-1:0]   s2_m_q;
  logic [2:0][MW-1:0]   m_d;

  // luminance
  logic signed [ACC_W-1:0] acc;
  logic signed [VAL_W-1:0] lum_ext;
  logic                    s3_valid_q;
  logic                    s3_method_q;
  logic [2:0][IN_W-1:0]    s3_c_q;
  logic [VAL_W-1:0]        s3_gray_q;

  // mode select, feeds the bisection chain
  logic signed [VAL_W-1:0] cx [3];
  logic [2:0]              c_in_rng;
  ctl_t                    s4_ctl_d, s4_ctl_q;
  logic [2:0][VAL_W-1:0]   s4_d_d, s4_d_q;
  logic [2:0][VAL_W-1:0]   s4_r_d, s4_r_q;
  logic [VAL_W-1:0]        s4_gray_q;

  // bisection chain
  ctl_t                  st_ctl  [BISECT_STEPS+1];
  logic [TW-1:0]         st_lo   [BISECT_STEPS+1];
  logic [TW-1:0]         st_hi   [BISECT_STEPS+1];
  logic [VAL_W-1:0]      st_gray [BISECT_STEPS+1];
  logic [2:0][VAL_W-1:0] st_d    [BISECT_STEPS+1];
  logic [2:0][VAL_W-1:0] st_r    [BISECT_STEPS+1];

  // output side
  logic                  emit;
  logic [2:0][OUT_W-1:0] lst_r;
  logic [2:0][OUT_W-1:0] out_r_q, out_r_d;
  logic [2:0][OUT_W-1:0] skid_r_q, skid_r_d;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_method_q <= 1'b0;
    end else if (cfg_i.valid) begin
      map_method_q <= cfg_i.map_method;
    end
  end

  // advance the whole pipeline unless the skid word is waiting
  assign pipe_en    = !skid_valid_q;
  assign in_i.ready = pipe_en;

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_method_q <= map_method_q;
      s1_c_q      <= {in_i.blue_in, in_i.green_in, in_i.red_in};
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    m_d[0] = $signed(s1_c_q[0]) * $signed({1'b0, W_RED});
    m_d[1] = $signed(s1_c_q[1]) * $signed({1'b0, W_GREEN});
    m_d[2] = $signed(s1_c_q[2]) * $signed({1'b0, W_BLUE});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_method_q <= s1_method_q;
      s2_c_q      <= s1_c_q;
      s2_m_q      <= m_d;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Sum, round half up, floor by the weight scale (upper bits), clamp to [0,1].
  assign acc = $signed(s2_m_q[0]) + $signed(s2_m_q[1]) + $signed(s2_m_q[2]) + LUM_RND;
  assign lum_ext = {{(VAL_W-LW){acc[ACC_W-1]}}, acc[ACC_W-1:W_BITS]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_method_q <= s2_method_q;
      s3_c_q      <= s2_c_q;
      s3_gray_q   <= clamp_unit(lum_ext);
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Clip mode and in-gamut pixels bypass the search; the rest start at gray.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cx[i]       = {{(VAL_W-IN_W){s3_c_q[i][IN_W-1]}}, s3_c_q[i]};
      c_in_rng[i] = (cx[i] >= 0) && (cx[i] <= ONE);
      s4_d_d[i]   = cx[i] - $signed(s3_gray_q);
    end
    s4_ctl_d.valid = s3_valid_q;
    s4_ctl_d.skip  = 1'b1;
    if (!s3_method_q) begin
      for (int i = 0; i < 3; i++) begin
        s4_r_d[i] = clamp_unit(cx[i]);
      end
    end else if (&c_in_rng) begin
      for (int i = 0; i < 3; i++) begin
        s4_r_d[i] = cx[i];
      end
    end else begin
      s4_ctl_d.skip = 1'b0;
      for (int i = 0; i < 3; i++) begin
        s4_r_d[i] = s3_gray_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_ctl_q <= '0;
    end else if (pipe_en) begin
      s4_ctl_q <= s4_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s4_gray_q <= s3_gray_q;
      s4_d_q    <= s4_d_d;
      s4_r_q    <= s4_r_d;
    end
  end

  assign st_ctl[0]  = s4_ctl_q;
  assign st_lo[0]   = '0;
  assign st_hi[0]   = T_FULL;
  assign st_gray[0] = s4_gray_q;
  assign st_d[0]    = s4_d_q;
  assign st_r[0]    = s4_r_q;

  // ---------------------------------------------------------------- bisection
  for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
    rgbgm_step #(
      .BISECT_STEPS (BISECT_STEPS),
      .FRAC_BITS    (FRAC_BITS),
      .VAL_W        (VAL_W)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .ctl_i  (st_ctl[k]),
      .lo_i   (st_lo[k]),
      .hi_i   (st_hi[k]),
      .gray_i (st_gray[k]),
      .d_i    (st_d[k]),
      .r_i    (st_r[k]),
      .ctl_o  (st_ctl[k+1]),
      .lo_o   (st_lo[k+1]),
      .hi_o   (st_hi[k+1]),
      .gray_o (st_gray[k+1]),
      .d_o    (st_d[k+1]),
      .r_o    (st_r[k+1])
    );
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lst_r[i] = st_r[BISECT_STEPS][i][OUT_W-1:0];
    end
  end

  assign emit = pipe_en && st_ctl[BISECT_STEPS].valid;

  // Load the output word from the skid first; park a word in the skid
  // when the output register is held.
  always_comb begin
    out_valid_d  = out_valid_q && !out_o.ready;
    out_r_d      = out_r_q;
    skid_valid_d = skid_valid_q;
    skid_r_d     = skid_r_q;
    if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_r_d      = skid_r_q;
        skid_valid_d = 1'b0;
      end else if (emit) begin
        out_valid_d = 1'b1;
        out_r_d     = lst_r;
      end
    end else if (emit) begin
      skid_valid_d = 1'b1;
      skid_r_d     = lst_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_r_q  <= out_r_d;
    skid_r_q <= skid_r_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.red_out   = out_r_q[0];
  assign out_o.green_out = out_r_q[1];
  assign out_o.blue_out  = out_r_q[2];

`ifndef SYNTHESIS
  // a parked word implies the output register is occupied
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  // the skid fills only when the output word was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_o.ready))
    else $error("skid filled while output could advance");

  // a searched pixel leaves with its interval narrowed to one step
  a_bisect_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_ctl[BISECT_STEPS].valid && !st_ctl[BISECT_STEPS].skip) |->
      ((st_hi[BISECT_STEPS] - st_lo[BISECT_STEPS]) == TW'(1)))
    else $error("bisection interval not fully narrowed");
`endif

endmodule

// ===== bench/gamut_checker.sv =====
// Watches the mapper's channels, predicts each mapped pixel and compares the results.
module gamut_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  rgbgm_cfg_if  cfg_i,
  rgbgm_in_if   pix_i,
  rgbgm_out_if  res_i,
  output int    pending_o,
  output int    fails_o
);
  import rgbgm_pkg::*;

  localparam int unsigned STEPS = BISECT_STEPS_DEF;
  localparam longint      UNIT  = longint'(1) << FRAC_BITS_DEF;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_res_t;

  rgb_res_t mapped_px [$];
  rgb_res_t want;
  logic     hue_mode_q;
  int       fail_count;

  assign fails_o = fail_count;

  function automatic longint clamp_unit(input longint v);
    if (v < 0) return 0;
    if (v > UNIT) return UNIT;
    return v;
  endfunction

  function automatic bit fits_unit(input longint v [3]);
    return v[0] >= 0 && v[0] <= UNIT && v[1] >= 0 && v[1] <= UNIT &&
           v[2] >= 0 && v[2] <= UNIT;
  endfunction

  // Map one pixel into the unit cube: clip per channel, or blend toward the
  // clamped Rec.709 gray with the largest in-gamut factor found by bisection.
  function automatic rgb_res_t gamut_map(input logic signed [IN_W-1:0] r, g, b,
                                         input logic hue_mode);
    longint   chan   [3];
    longint   mapped [3];
    longint   probe  [3];
    longint   gray;
    longint   t;
    longint   t_lo;
    longint   t_hi;
    rgb_res_t res;
    chan[0] = longint'(r);
    chan[1] = longint'(g);
    chan[2] = longint'(b);
    if (!hue_mode) begin
      for (int i = 0; i < 3; i++) mapped[i] = clamp_unit(chan[i]);
    end else if (fits_unit(chan)) begin
      mapped = chan;
    end else begin
      gray = longint'(W_RED) * chan[0] + longint'(W_GREEN) * chan[1] +
             longint'(W_BLUE) * chan[2] + (longint'(1) << (W_BITS - 1));
      gray = clamp_unit(gray >>> W_BITS);
      t_lo = 0;
      t_hi = longint'(1) << STEPS;
      for (int i = 0; i < 3; i++) mapped[i] = gray;
      for (int k = 0; k < STEPS; k++) begin
        t = (t_lo + t_hi) >>> 1;
        for (int i = 0; i < 3; i++) begin
          probe[i] = gray + (((chan[i] - gray) * t + (longint'(1) << (STEPS - 1))) >>> STEPS);
        end
        if (fits_unit(probe)) begin
          t_lo   = t;
          mapped = probe;
        end else begin
          t_hi = t;
        end
      end
    end
    res.red   = OUT_W'(mapped[0]);
    res.green = OUT_W'(mapped[1]);
    res.blue  = OUT_W'(mapped[2]);
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("gamut_checker: %s", msg);
    fail_count++;
  endtask

  task automatic compare_field(input string field, input logic [OUT_W-1:0] exp_v, got_v);
    if (exp_v !== got_v) begin
      report_error($sformatf("%s mismatch: expected %0d, got %0d", field, exp_v, got_v));
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_mode_q = 1'b0;
      mapped_px.delete();
      pending_o <= 0;
    end else begin
      // Check the result word first so a stray word never meets a fresh prediction.
      if (res_i.valid && res_i.ready) begin
        if (mapped_px.size() == 0) begin
          report_error($sformatf("unexpected result word %0d %0d %0d",
                                 res_i.red_out, res_i.green_out, res_i.blue_out));
        end else begin
          want = mapped_px.pop_front();
          compare_field("red", want.red, res_i.red_out);
          compare_field("green", want.green, res_i.green_out);
          compare_field("blue", want.blue, res_i.blue_out);
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        mapped_px.push_back(gamut_map(pix_i.red_in, pix_i.green_in, pix_i.blue_in,
                                      hue_mode_q));
      end
      if (cfg_i.valid && cfg_i.ready) hue_mode_q = cfg_i.map_method;
      pending_o <= mapped_px.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus and verdict for the RGB gamut mapper, with the checker beside the block.
module tb_top;
  import rgbgm_pkg::*;

  // Method register codes.
  localparam logic METHOD_CLIP = 1'b0;
  localparam logic METHOD_HUE  = 1'b1;

  localparam int          UNIT         = 1 << FRAC_BITS_DEF;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Tail wait: the pipeline depth, with some slack beyond it.
  localparam int unsigned TAIL_CYCLES  = 2 * BISECT_STEPS_DEF + 5 + 20;
  // Watchdog limit: the slowest correct run, taken many times over.
  localparam int unsigned RUN_LIMIT    = 200000;

  typedef enum int unsigned {CH_GAMUT, CH_NEAR, CH_WIDE, CH_CORNER} chan_kind_e;

  typedef struct packed {
    logic signed [IN_W-1:0] red;
    logic signed [IN_W-1:0] green;
    logic signed [IN_W-1:0] blue;
  } pix_t;

  logic        clk;
  logic        rst_n;
  int          pending;
  int          fails;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_req;
  int unsigned cycles;

  // Directed pixels: zero, white, field extremes, just outside the cube on
  // each side, a gamut corner, wild mixes, and grays that clamp to 0 and 1.
  int corner_px [12][3] = '{
    '{0, 0, 0},
    '{65536, 65536, 65536},
    '{524287, 524287, 524287},
    '{-524288, -524288, -524288},
    '{-1, 65537, 32768},
    '{65536, 0, 0},
    '{-524288, 524287, 0},
    '{524287, -524288, 524287},
    '{98304, 32768, -16384},
    '{-65536, -65536, -32768},
    '{131072, 131072, 196608},
    '{0, 65536, -1}
  };

  // Method per random phase; the clip method appears twice so both extremes
  // of the register are revisited after the directed part.
  logic phase_method [PHASES] = '{METHOD_HUE, METHOD_CLIP, METHOD_HUE, METHOD_HUE,
                                  METHOD_HUE, METHOD_CLIP, METHOD_HUE, METHOD_HUE};

  rgbgm_cfg_if cfg_w ();
  rgbgm_in_if  pix_w ();
  rgbgm_out_if res_w ();

  rgb_gamut_mapper_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_w),
    .in_i   (pix_w),
    .out_o  (res_w)
  );

  gamut_checker u_gamut_check (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_i     (cfg_w),
    .pix_i     (pix_w),
    .res_i     (res_w),
    .pending_o (pending),
    .fails_o   (fails)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run as failed if it overstays the limit.
  initial begin
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Result side: drop ready at random, or hold it low for a long stretch once
  // asked, so the pipeline fills and the block has to stall its input.
  initial begin : result_sink
    int unsigned stall_left;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    res_w.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        stall_left = HOLD_CYCLES;
        hold_done  = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_w.ready <= 1'b0;
      end else begin
        res_w.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Draw one channel value of the given flavor.
  function automatic logic signed [IN_W-1:0] rand_channel(input chan_kind_e kind);
    int corner_vals [6];
    corner_vals = '{0, 65536, -1, 65537, -524288, 524287};
    case (kind)
      CH_GAMUT: return IN_W'($urandom_range(UNIT));
      CH_NEAR:  return IN_W'(int'($urandom_range(UNIT + UNIT / 2)) - UNIT / 4);
      CH_WIDE:  return IN_W'($urandom());
      default:  return IN_W'(corner_vals[$urandom_range(5)]);
    endcase
  endfunction

  // Write the method register; call only while the block is drained.
  task automatic write_method(input logic method);
    cfg_w.map_method <= method;
    cfg_w.valid      <= 1'b1;
    do @(posedge clk); while (!cfg_w.ready);
    cfg_w.valid <= 1'b0;
  endtask

  // Offer one pixel word after a random idle gap and hold it until accepted.
  // Valid stays high into the next word when no gap is drawn.
  task automatic send_pixel(input pix_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_w.valid <= 1'b0;
      @(posedge clk);
    end
    pix_w.red_in   <= px.red;
    pix_w.green_in <= px.green;
    pix_w.blue_in  <= px.blue;
    pix_w.valid    <= 1'b1;
    do @(posedge clk); while (!pix_w.ready);
  endtask

  // Wait until every predicted pixel has come back. The first edge lets the
  // checker's count catch up with the word just accepted.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    pix_t        px;
    int unsigned shape;
    chan_kind_e  kind [3];
    logic signed [IN_W-1:0] ch [3];

    // Drive every input to a known value before the first edge.
    rst_n            <= 1'b0;
    pix_w.valid      <= 1'b0;
    pix_w.red_in     <= '0;
    pix_w.green_in   <= '0;
    pix_w.blue_in    <= '0;
    cfg_w.valid      <= 1'b0;
    cfg_w.map_method <= METHOD_CLIP;
    hold_req         = 1'b0;
    src_idle_pct     = 28;
    snk_idle_pct     = 28;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the same corner pixels under both methods.
    for (int m = 0; m < 2; m++) begin
      write_method((m == 0) ? METHOD_CLIP : METHOD_HUE);
      for (int i = 0; i < 12; i++) begin
        px.red   = IN_W'(corner_px[i][0]);
        px.green = IN_W'(corner_px[i][1]);
        px.blue  = IN_W'(corner_px[i][2]);
        send_pixel(px);
      end
      pix_w.valid <= 1'b0;
      wait_drained();
    end

    // Random part: mostly in-gamut or mildly out-of-gamut pixels, which drive
    // the bisection through many outcomes, plus wide and corner values.
    for (int p = 0; p < PHASES; p++) begin
      write_method(phase_method[p]);
      // Phase 3 runs with no idling on either side.
      src_idle_pct = (p == 3) ? 0 : 28;
      snk_idle_pct = (p == 3) ? 0 : 28;
      // Phase 5 starts with a long hold on the result side.
      if (p == 5) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Phase 6 pauses halfway until every result is back.
        if (p == 6 && n == PHASE_ITEMS / 2) begin
          pix_w.valid <= 1'b0;
          wait_drained();
        end
        shape = $urandom_range(99);
        for (int c = 0; c < 3; c++) begin
          if (shape < 25) begin
            kind[c] = CH_GAMUT;
          end else if (shape < 65) begin
            kind[c] = CH_NEAR;
          end else if (shape < 85) begin
            kind[c] = ($urandom_range(2) == 0) ? CH_WIDE : CH_GAMUT;
          end else begin
            kind[c] = chan_kind_e'($urandom_range(3));
          end
          ch[c] = rand_channel(kind[c]);
        end
        px.red   = ch[0];
        px.green = ch[1];
        px.blue  = ch[2];
        send_pixel(px);
      end
      pix_w.valid <= 1'b0;
      wait_drained();
    end

    // Let any stray word surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rgbgm_pkg.sv
hdl/rgbgm_if.sv
hdl/rgbgm_step.sv
hdl/rgb_gamut_mapper_top.sv
bench/gamut_checker.sv
bench/tb_top.sv
